>>> rtl/nwps_pkg.sv
// Package for the nibble wildcard pattern scan block.
// Holds register indexes, pattern storage sizes and parameter defaults.
// No dependencies.
package nwps_pkg;

	// pattern storage is fixed by the register map: 16 bytes, 2 care bits each
	localparam int PAT_STORE_BYTES = 16;
	localparam int PAT_BITS        = PAT_STORE_BYTES * 8;
	localparam int CARE_BITS       = PAT_STORE_BYTES * 2;
	localparam int LEN_REG_W       = 5;
	localparam int OCC_W           = 16;
	localparam int ADDR_W          = 64;
	localparam int OFFSET_W        = 32;
	localparam int MPOS_W          = 32;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	localparam int PATTERN_BYTES_DEF = 16;
	localparam int POSITION_BITS_DEF = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW   = 3'd0,
		REG_PATTERN_HIGH  = 3'd1,
		REG_CARE_MASK     = 3'd2,
		REG_PATTERN_LEN   = 3'd3,
		REG_OCCURRENCE    = 3'd4,
		REG_BASE_ADDRESS  = 3'd5,
		REG_RESULT_OFFSET = 3'd6
	} cfg_reg_t;

endpackage

>>> rtl/nibble_wildcard_pattern_scan_top.sv
// Top level of the nibble wildcard pattern scan.
// Holds the config registers, byte window, match counters and result register.
// Depends on nwps_pkg and nwps_match.
//
// Takes one byte per clock and gives at most one result per scan: the match
// selected by occurrence_index (found = 1, address = base + start + offset),
// or a not-found result on the byte flagged last_byte. An accepted byte is
// registered in the compare stage and compared against the pattern there; its
// result, if any, is registered in the result register. Sustained throughput is
// one byte per cycle as long as the output is not stalled. The compare stage
// holds a byte while the result register is full and stalled, and the input
// stalls only then. Configuration writes are always taken and are meant to
// happen between scans.
module nibble_wildcard_pattern_scan_top
	import nwps_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [ADDR_W-1:0]     match_address,
	output logic [MPOS_W-1:0]     match_position
);

	localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
	localparam logic [LEN_W-1:0] P_LEN = LEN_W'(PATTERN_BYTES);

	// config registers
	logic [63:0]          pat_low_q;
	logic [63:0]          pat_high_q;
	logic [CARE_BITS-1:0] care_q;
	logic [LEN_REG_W-1:0] plen_q;
	logic [OCC_W-1:0]     occ_q;
	logic [ADDR_W-1:0]    base_q;
	logic [OFFSET_W-1:0]  offset_q;

	// compare stage
	logic                            valid_s1;
	logic                            last_s1;
	logic [PATTERN_BYTES-1:0][7:0]   win_s1;
	logic [LEN_W-1:0]                fill_s1;
	logic [POSITION_BITS-1:0]        pos_s1;

	// scan state
	logic [OCC_W-1:0] seen_q;
	logic             reported_q;

	// result register
	logic              out_valid_q;
	logic              found_q;
	logic [ADDR_W-1:0] addr_q;
	logic [MPOS_W-1:0] mpos_q;

	logic                     in_acc;
	logic                     proc;
	logic [LEN_W-1:0]         eff_len;
	logic                     hit;
	logic                     report;
	logic                     emit;
	logic [POSITION_BITS-1:0] start;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			plen_q     <= LEN_REG_W'(1);
			occ_q      <= '0;
			base_q     <= '0;
			offset_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:   pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:  pat_high_q <= cfg_data;
				REG_CARE_MASK:     care_q     <= cfg_data[CARE_BITS-1:0];
				REG_PATTERN_LEN:   plen_q     <= cfg_data[LEN_REG_W-1:0];
				REG_OCCURRENCE:    occ_q      <= cfg_data[OCC_W-1:0];
				REG_BASE_ADDRESS:  base_q     <= cfg_data;
				REG_RESULT_OFFSET: offset_q   <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// compare stage advances when the result register can take its output
	assign proc     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;
	assign in_acc   = in_valid && !in_stall;

	assign eff_len = (32'(plen_q) > 32'(PATTERN_BYTES)) ? P_LEN : LEN_W'(plen_q);

	// window shifts at accept; last_s1 still flags the previous request,
	// and resets high so the first byte starts a fresh scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b1;
			fill_s1  <= '0;
			pos_s1   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				last_s1  <= last_byte;
				if (last_s1) begin
					fill_s1 <= LEN_W'(1);
					pos_s1  <= '0;
				end else begin
					fill_s1 <= (fill_s1 == P_LEN) ? P_LEN : fill_s1 + LEN_W'(1);
					pos_s1  <= pos_s1 + POSITION_BITS'(1);
				end
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
				win_s1[i] <= win_s1[i-1];
			end
			win_s1[0] <= data_byte;
		end
	end

	nwps_match #(
		.PATTERN_BYTES(PATTERN_BYTES),
		.LEN_W        (LEN_W)
	) u_match (
		.win    (win_s1),
		.len    (eff_len),
		.fill   (fill_s1),
		.pattern({pat_high_q, pat_low_q}),
		.care   (care_q),
		.hit    (hit)
	);

	assign report = hit && !reported_q && (seen_q == occ_q);
	assign emit   = report || (last_s1 && !reported_q);
	assign start  = pos_s1 - POSITION_BITS'(eff_len) + POSITION_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (report) begin
				reported_q <= 1'b1;
			end else if (hit && !reported_q && seen_q != {OCC_W{1'b1}}) begin
				seen_q <= seen_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			found_q <= report;
			if (report) begin
				addr_q <= base_q + ADDR_W'(start) + ADDR_W'(offset_q);
				mpos_q <= MPOS_W'(start);
			end else begin
				addr_q <= '0;
				mpos_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_address  = addr_q;
	assign match_position = mpos_q;

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_address == '0 && match_position == '0)
		else $error("not-found result carries nonzero address or position");

	a_stall_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a held request");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> seen_q == '0 && !reported_q)
		else $error("scan state not cleared after last byte");

endmodule

>>> rtl/nwps_match.sv
// Window compare for the nibble wildcard pattern scan.
// Checks the newest len window bytes against the pattern, nibble by nibble.
// Depends on nwps_pkg.
module nwps_match
	import nwps_pkg::*;
#(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
	parameter int LEN_W         = $clog2(PATTERN_BYTES + 1)
) (
	input  logic [PATTERN_BYTES-1:0][7:0] win,
	input  logic [LEN_W-1:0]              len,
	input  logic [LEN_W-1:0]              fill,
	input  logic [PAT_BITS-1:0]           pattern,
	input  logic [CARE_BITS-1:0]          care,
	output logic                          hit
);

	localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

	logic [PATTERN_BYTES-1:0][7:0] pbyte;
	logic [PATTERN_BYTES-1:0][7:0] pcare;
	logic [PATTERN_BYTES-1:0]      lane_ok;

	// bytes past the stored pattern are full wildcards
	for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_pat
		if (k < PAT_STORE_BYTES) begin : g_store
			assign pbyte[k] = pattern[8*k +: 8];
			assign pcare[k] = {{4{care[2*k+1]}}, {4{care[2*k]}}};
		end else begin : g_wild
			assign pbyte[k] = 8'h00;
			assign pcare[k] = 8'h00;
		end
	end

	// pattern byte k lines up with window slot len-1-k (slot 0 is newest)
	always_comb begin
		int   idx;
		logic [7:0] d;
		idx = 0;
		d   = 8'h00;
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			lane_ok[k] = 1'b1;
			if (k < int'(len)) begin
				idx        = int'(len) - 1 - k;
				d          = win[idx[IDX_W-1:0]];
				lane_ok[k] = ((d ^ pbyte[k]) & pcare[k]) == 8'h00;
			end
		end
	end

	assign hit = (len != '0) && (fill >= len) && (&lane_ok);

endmodule
